// File: design/fast_inverse_square_root_unit_macros.svh
// Assertion macros for the fast inverse square root unit.
// Uses i_clk and i_rst_n of the including module.
`ifndef FAST_INVERSE_SQUARE_ROOT_UNIT_MACROS_SVH
`define FAST_INVERSE_SQUARE_ROOT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FISR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FISR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FISR_ASSERT_IMP(lbl, ante, cons)
`define FISR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: design/fisr_pkg.sv
// Package for the fast inverse square root unit.
// Constants and single-precision multiply, add and rounding functions; no dependencies.
`timescale 1ns / 1ps
package fisr_pkg;

    localparam logic [31:0] MAGIC        = 32'h5f3759df;
    localparam logic [31:0] ONE_HALF     = 32'h3f000000;
    localparam logic [31:0] THREE_HALVES = 32'h3fc00000;
    localparam logic [31:0] QNAN         = 32'h7fc00000;
    localparam logic [31:0] POS_INF      = 32'h7f800000;
    localparam int          MW           = 51;

    typedef logic [31:0] t_word;

    function automatic logic [5:0] lzc(input logic [MW-1:0] m);
        logic [5:0] n;
        n = 6'(MW);
        for (int k = 0; k < MW; k++) begin
            if (m[k]) n = 6'(MW - 1 - k);
        end
        return n;
    endfunction

    // mantissa normalised with leading one at bit MW-1; e is the biased exponent
    function automatic t_word rpack(input logic s, input logic signed [11:0] e,
                                    input logic [MW-1:0] m);
        logic [5:0]    sh;
        logic [MW-1:0] shd;
        logic          lost;
        logic [23:0]   mm;
        logic          g;
        logic          st;
        logic [7:0]    ef;
        logic [31:0]   sum;
        if (e >= 12'sd255) return {s, POS_INF[30:0]};
        if (e <= 12'sd0) begin
            sh = ((12'sd1 - e) > 12'sd51) ? 6'd51 : 6'((12'sd1 - e));
            ef = 8'd0;
        end else begin
            sh = 6'd0;
            ef = e[7:0];
        end
        shd  = m >> sh;
        lost = |(m & ((MW'(1) << sh) - MW'(1)));
        mm   = shd[MW-1 -: 24];
        g    = shd[MW-25];
        st   = (|shd[MW-26:0]) | lost;
        sum  = {1'b0, ef, mm[22:0]} + 32'(g & (st | mm[0]));
        if (sum[30:23] == 8'hff) return {s, POS_INF[30:0]};
        return {s, sum[30:0]};
    endfunction

    function automatic t_word fmul(input t_word a, input t_word b);
        logic               s;
        logic [23:0]        ma;
        logic [23:0]        mb;
        logic [47:0]        p;
        logic [MW-1:0]      pw;
        logic [5:0]         lz;
        logic signed [11:0] e;
        logic               an, bn, ai, bi, az, bz;
        s  = a[31] ^ b[31];
        an = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
        bn = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
        ai = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
        bi = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
        az = (a[30:0] == 31'd0);
        bz = (b[30:0] == 31'd0);
        if (an || bn || (ai && bz) || (bi && az)) return QNAN;
        if (ai || bi) return {s, POS_INF[30:0]};
        if (az || bz) return {s, 31'd0};
        ma = {(a[30:23] != 8'd0), a[22:0]};
        mb = {(b[30:23] != 8'd0), b[22:0]};
        p  = ma * mb;
        pw = {p, 3'b000};
        lz = lzc(pw);
        e  = 12'(a[30:23] == 8'd0 ? 8'd1 : a[30:23])
           + 12'(b[30:23] == 8'd0 ? 8'd1 : b[30:23])
           - 12'sd126 - 12'(lz);
        return rpack(s, e, pw << lz);
    endfunction

    function automatic t_word fadd(input t_word x, input t_word y);
        t_word              a;
        t_word              b;
        logic [7:0]         ea;
        logic [7:0]         eb;
        logic [7:0]         d;
        logic [MW-1:0]      am;
        logic [MW-1:0]      bm;
        logic [MW-1:0]      bs;
        logic               lost;
        logic [MW-1:0]      r;
        logic [5:0]         lz;
        logic               xn, yn, xi, yi;
        xn = (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
        yn = (y[30:23] == 8'hff) && (y[22:0] != 23'd0);
        xi = (x[30:23] == 8'hff) && (x[22:0] == 23'd0);
        yi = (y[30:23] == 8'hff) && (y[22:0] == 23'd0);
        if (xn || yn || (xi && yi && (x[31] != y[31]))) return QNAN;
        if (xi) return x;
        if (yi) return y;
        if (x[30:0] >= y[30:0]) begin
            a = x;
            b = y;
        end else begin
            a = y;
            b = x;
        end
        ea   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        d    = ea - eb;
        am   = {1'b0, (a[30:23] != 8'd0), a[22:0], 26'd0};
        bm   = {1'b0, (b[30:23] != 8'd0), b[22:0], 26'd0};
        if (d > 8'd50) begin
            bs   = '0;
            lost = |bm;
        end else begin
            bs   = bm >> d;
            lost = |(bm & ((MW'(1) << d) - MW'(1)));
        end
        bs[0] = bs[0] | lost;
        r  = (a[31] != b[31]) ? (am - bs) : (am + bs);
        if (r == '0) return {a[31] & b[31], 31'd0};
        lz = lzc(r);
        return rpack(a[31], 12'(ea) + 12'sd1 - 12'(lz), r << lz);
    endfunction

endpackage

// File: design/fast_inverse_square_root_unit.sv
// Fast inverse square root unit: five-stage pipeline, one word per cycle while i_ready does not stall it.
// A word passes stage registers 0 through 4 in order; stage 4 drives o_valid, and a low i_ready holds it.
// Stages: guess and x*0.5, half*y, *y, 1.5-t, y*t (last stage is the output register).
// Synchronous active-low reset empties the pipeline; payload registers are not reset.
// Depends on fisr_pkg and fast_inverse_square_root_unit_macros.svh.
`timescale 1ns / 1ps
`include "fast_inverse_square_root_unit_macros.svh"
module fast_inverse_square_root_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [31:0]         i_value_bits,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_rsqrt_bits
);
    import fisr_pkg::*;

    logic [4:0] r_v;
    logic [4:0] n_v;
    logic [4:0] w_rdy;
    logic       w_out_nan;
    t_word      r_half, r_y0, r_t1, r_y1, r_t2, r_y2, r_t3, r_y3, r_out;

    always_comb begin
        w_rdy[4] = !r_v[4] || i_ready;
        for (int k = 3; k >= 0; k--) w_rdy[k] = !r_v[k] || w_rdy[k+1];
        n_v[0] = w_rdy[0] ? i_valid : r_v[0];
        for (int k = 1; k < 5; k++) n_v[k] = w_rdy[k] ? r_v[k-1] : r_v[k];
    end

    assign o_ready      = w_rdy[0];
    assign o_valid      = r_v[4];
    assign o_rsqrt_bits = r_out;
    assign w_out_nan    = (r_out[30:23] == 8'hff) && (r_out[22:0] != 23'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_half <= fmul(i_value_bits, ONE_HALF);
            r_y0   <= MAGIC - {i_value_bits[31], i_value_bits[31:1]};
        end
        if (w_rdy[1] && r_v[0]) begin
            r_t1 <= fmul(r_half, r_y0);
            r_y1 <= r_y0;
        end
        if (w_rdy[2] && r_v[1]) begin
            r_t2 <= fmul(r_t1, r_y1);
            r_y2 <= r_y1;
        end
        if (w_rdy[3] && r_v[2]) begin
            r_t3 <= fadd(THREE_HALVES, {~r_t2[31], r_t2[30:0]});
            r_y3 <= r_y2;
        end
        if (w_rdy[4] && r_v[3]) begin
            r_out <= fmul(r_y3, r_t3);
        end
    end

    `FISR_ASSERT_NXT(a_adv, r_v[3] && w_rdy[4], r_v[4])
    `FISR_ASSERT_NXT(a_hold, r_v[1] && !w_rdy[2], r_v[1] && $stable(r_t1))
    `FISR_ASSERT_IMP(a_nan, o_valid && w_out_nan, o_rsqrt_bits == QNAN)

endmodule

// File: test/tb_top.sv
// Testbench for fast_inverse_square_root_unit: directed table then random words, checked against
// table values where given, else a bit-accurate single-precision predictor. Depends on fisr_pkg.
`timescale 1ns / 1ps
module tb_top;
    import fisr_pkg::*;

    typedef struct {
        t_word value;
        bit    known;
        t_word rsqrt;
    } t_row;

    localparam int N_RANDOM   = 1000;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_AT    = 40;
    localparam int HOLD_LEN   = 200;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_word i_value_bits;
    logic  o_valid;
    logic  i_ready;
    t_word o_rsqrt_bits;

    t_word expected_rsqrt[$];
    int    mismatches;
    int    words_out;
    int    idle_cycles;
    bit    burst_mode;

    fast_inverse_square_root_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value_bits (i_value_bits),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_rsqrt_bits (o_rsqrt_bits)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit is_nan(t_word a);
        return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    endfunction

    function automatic bit is_inf(t_word a);
        return (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    endfunction

    // value = m * 2^e, m nonzero; round to nearest even with gradual underflow
    function automatic t_word sp_round(logic s, int e, logic [63:0] m);
        logic [127:0] w;
        logic [127:0] rem;
        logic [127:0] hf;
        logic [31:0]  q;
        logic [31:0]  bits;
        int           b;
        int           sh;
        w = {64'd0, m};
        while (!w[63]) begin
            w = w << 1;
            e = e - 1;
        end
        b = e + 63 + 127;
        if (b >= 255) return {s, POS_INF[30:0]};
        sh = (b >= 1) ? 40 : 41 - b;
        if (sh > 66) sh = 66;
        q    = 32'(w >> sh);
        rem  = w & ((128'd1 << sh) - 128'd1);
        hf   = 128'd1 << (sh - 1);
        bits = (b >= 1) ? ((32'(b - 1) << 23) + q) : q;
        if (rem > hf || (rem == hf && q[0])) bits = bits + 32'd1;
        if (bits >= POS_INF) return {s, POS_INF[30:0]};
        return {s, bits[30:0]};
    endfunction

    function automatic t_word sp_mul(t_word a, t_word b);
        logic s;
        int   ea;
        int   eb;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return QNAN;
        if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0)) return QNAN;
        if (is_inf(a) || is_inf(b)) return {s, POS_INF[30:0]};
        if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
        ea = ((a[30:23] == 0) ? 1 : int'(a[30:23])) - 150;
        eb = ((b[30:23] == 0) ? 1 : int'(b[30:23])) - 150;
        return sp_round(s, ea + eb,
                        64'({a[30:23] != 0, a[22:0]}) * 64'({b[30:23] != 0, b[22:0]}));
    endfunction

    function automatic t_word sp_add(t_word x, t_word y);
        t_word       a;
        t_word       b;
        int          ea;
        int          eb;
        int          d;
        logic [63:0] am;
        logic [63:0] bm0;
        logic [63:0] bm;
        logic [63:0] r;
        if (is_nan(x) || is_nan(y)) return QNAN;
        if (is_inf(x) && is_inf(y) && x[31] != y[31]) return QNAN;
        if (is_inf(x)) return x;
        if (is_inf(y)) return y;
        if (x[30:0] == 0 && y[30:0] == 0) return {x[31] & y[31], 31'd0};
        if (x[30:0] == 0) return y;
        if (y[30:0] == 0) return x;
        if (x[30:0] >= y[30:0]) begin
            a = x;
            b = y;
        end else begin
            a = y;
            b = x;
        end
        ea  = ((a[30:23] == 0) ? 1 : int'(a[30:23])) - 150;
        eb  = ((b[30:23] == 0) ? 1 : int'(b[30:23])) - 150;
        d   = ea - eb;
        am  = 64'({a[30:23] != 0, a[22:0]}) << 30;
        bm0 = 64'({b[30:23] != 0, b[22:0]}) << 30;
        if (d > 60) bm = 64'd1;
        else bm = (bm0 >> d) | 64'(|(bm0 & ((64'd1 << d) - 64'd1)));
        r = (a[31] == b[31]) ? am + bm : am - bm;
        if (r == 0) return 32'd0;
        return sp_round(a[31], ea - 30, r);
    endfunction

    function automatic t_word rsqrt_estimate_of(t_word x);
        t_word y;
        t_word half;
        t_word t;
        y    = MAGIC - {x[31], x[31:1]};
        half = sp_mul(x, ONE_HALF);
        t    = sp_mul(half, y);
        t    = sp_mul(t, y);
        t    = sp_add(THREE_HALVES, {~t[31], t[30:0]});
        y    = sp_mul(y, t);
        if (is_nan(y)) y = QNAN;
        return y;
    endfunction

    function automatic t_word random_operand();
        case ($urandom_range(0, 5))
            0: return {1'($urandom), 8'd0, 23'($urandom)};
            1: return {1'($urandom), 8'($urandom_range(100, 154)), 23'($urandom)};
            2: return {1'b0, 8'($urandom_range(0, 254)), 23'($urandom)};
            3: return {1'($urandom), 8'hff, 23'($urandom_range(0, 3))};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(t_row row);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_value_bits <= row.value;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        expected_rsqrt.push_back(row.known ? row.rsqrt : rsqrt_estimate_of(row.value));
    endtask

    // receiver: random stalls per word (none in burst mode), one long hold-off once HOLD_AT words are out
    initial begin
        int  gap;
        bit  held;
        held    = 1'b0;
        i_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (!held && words_out >= HOLD_AT) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                if (burst_mode) gap = 0;
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            words_out <= words_out + 1;
            if (expected_rsqrt.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("unexpected word %h", o_rsqrt_bits);
            end else begin
                t_word want;
                want = expected_rsqrt.pop_front();
                if (want !== o_rsqrt_bits) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("rsqrt mismatch: expected %h actual %h", want, o_rsqrt_bits);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_row table_rows[$];
        t_row row;
        int   n;
        mismatches   = 0;
        words_out    = 0;
        idle_cycles  = 0;
        burst_mode   = 1'b0;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_value_bits = '0;
        table_rows = '{
            '{32'h7f800000, 1'b1, 32'hff800000},
            '{32'h7fc00000, 1'b1, QNAN},
            '{32'h7f800001, 1'b1, QNAN},
            '{32'hffffffff, 1'b1, QNAN},
            '{32'h00000000, 1'b0, '0},
            '{32'h80000000, 1'b0, '0},
            '{32'h00000001, 1'b0, '0},
            '{32'h007fffff, 1'b0, '0},
            '{32'h00800000, 1'b0, '0},
            '{32'h3f800000, 1'b0, '0},
            '{32'h40800000, 1'b0, '0},
            '{32'h3e800000, 1'b0, '0},
            '{32'h7f7fffff, 1'b0, '0},
            '{32'hff800000, 1'b0, '0},
            '{32'hbf800000, 1'b0, '0},
            '{32'h80000001, 1'b0, '0},
            '{32'h5f3759df, 1'b0, '0},
            '{32'hfffffffe, 1'b0, '0}
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (table_rows[k]) send_word(table_rows[k]);
        row.known = 1'b0;
        row.rsqrt = '0;
        for (n = 0; n < N_RANDOM; n++) begin
            if (n % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0) || (n == 0);
            row.value = random_operand();
            send_word(row);
        end
        i_valid <= 1'b0;
        while (expected_rsqrt.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
